FILE: sv/osk_pkg.sv
// shared types and constants for the offset sorted set
package osk_pkg;

  localparam int CAPACITY_DEFAULT = 1024;
  localparam int VAL_W    = 43;   // stored value, signed
  localparam int OFS_W    = 42;   // global offset, signed
  localparam int SUM_W    = 44;   // real value before saturation
  localparam int ARG_W    = 20;
  localparam int RES_W    = 41;
  localparam int DEP_W    = 32;
  localparam int CNT_OUT_W = 11;
  localparam int RANK_W   = 21;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_SUB    = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_LOAD,
    CELL_COPY
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic signed [VAL_W-1:0] s;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVICT,
    ST_QUERY,
    ST_FINISH
  } state_t;

endpackage

FILE: sv/osk_cell.sv
// one cell of the sorted chain: a stored value, its valid bit and a read-out copy
module osk_cell (
  input  logic                              clk,
  input  logic                              rst,
  input  osk_pkg::cell_ctl_t                ctl,
  input  logic signed [osk_pkg::VAL_W-1:0]  prev_val,
  input  logic                              prev_valid,
  input  logic                              prev_gt,
  input  logic signed [osk_pkg::VAL_W-1:0]  next_val,
  input  logic                              next_valid,
  input  logic signed [osk_pkg::VAL_W-1:0]  next_cp,
  output logic signed [osk_pkg::VAL_W-1:0]  val,
  output logic                              valid,
  output logic                              gt,
  output logic signed [osk_pkg::VAL_W-1:0]  cp
);
  import osk_pkg::*;

  // an empty cell counts as larger than anything
  assign gt = !valid || (val > ctl.s);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctl.op)
        CELL_INSERT: valid <= valid | prev_valid;
        CELL_SHIFT:  valid <= next_valid;
        default:     valid <= valid;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_INSERT: begin
        if (prev_gt) begin
          val <= prev_val;
        end else if (gt) begin
          val <= ctl.s;
        end
      end
      CELL_SHIFT: val <= next_val;
      CELL_LOAD:  cp  <= val;
      CELL_COPY:  cp  <= next_cp;
      default: ;
    endcase
  end

endmodule

FILE: sv/offset_sorted_set_kth_largest.sv
// top level of the offset sorted set with k-th largest query
// Channels: s_axis (tdata = opcode, operand), m_axis (one result per item),
// and cfg (min_threshold write, always ready).
// Entries sit in a chain of CAPACITY cells kept in ascending order.
// Insert and add apply in idle, then finish loads the output register.
// Subtract applies the offset; the chain then shifts down one cell a cycle
// while the lowest entry is below the threshold, and the evict step moves on
// to finish once it finds the lowest entry at or above it.
// Query on a hit loads a copy of the chain and shifts it down until the wanted
// entry reaches cell 0; a miss goes straight to the finish step.
// Input is taken only in idle; a result waits in the output register while
// the receiver stalls and the block holds in its finish step until it is free.
// Reset (synchronous, rst high) empties the chain at once through the cell
// valid bits, clears offset, departed count, overflow flag and threshold.
// Results appear in the cycle after the finish step ends.
module offset_sorted_set_kth_largest #(
  parameter int CAPACITY = osk_pkg::CAPACITY_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] opcode, [21:2] operand, [23:22] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [40:0] kth_value, [41] kth_found, [73:42] departed_total,
  // [84:74] entry_count, [85] overflow, [87:86] zero
  output logic [87:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);
  import osk_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam logic signed [OFS_W:0] OFS_MAX = {2'b00, {(OFS_W-1){1'b1}}};
  localparam logic signed [OFS_W:0] OFS_MIN = {2'b11, {(OFS_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RES_MAX = {{(SUM_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] RES_MIN = {{(SUM_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

  state_t state, state_next;

  logic [ARG_W-1:0]        threshold;
  logic signed [OFS_W-1:0] offset;
  logic [CW-1:0]           count;
  logic [DEP_W-1:0]        departed;
  logic                    ovf;
  logic [IW-1:0]           rem;
  logic signed [RES_W-1:0] kval;
  logic                    found;

  cell_ctl_t ctl;
  logic signed [VAL_W-1:0] val_w [CAPACITY];
  logic                    valid_w [CAPACITY];
  logic                    gt_w [CAPACITY];
  logic signed [VAL_W-1:0] cp_w [CAPACITY];

  logic [1:0]        in_op;
  logic [ARG_W-1:0]  in_arg;
  logic              in_fire;
  logic              out_free;
  logic signed [OFS_W:0]   ofs_add, ofs_sub;
  logic signed [SUM_W-1:0] s_wide, low_real, cp_real;
  logic [RANK_W-1:0] count_r, diff_r;
  logic              hit;
  logic              below;
  logic [CW+CNT_OUT_W-1:0] count_ext;

  assign in_op     = s_axis_tdata[1:0];
  assign in_arg    = s_axis_tdata[21:2];
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !m_axis_tvalid || m_axis_tready;

  assign ofs_add  = {offset[OFS_W-1], offset} + $signed({{(OFS_W-ARG_W+1){1'b0}}, in_arg});
  assign ofs_sub  = {offset[OFS_W-1], offset} - $signed({{(OFS_W-ARG_W+1){1'b0}}, in_arg});
  assign s_wide   = $signed({{(SUM_W-ARG_W){1'b0}}, in_arg})
                  - $signed({{(SUM_W-OFS_W){offset[OFS_W-1]}}, offset});
  assign low_real = $signed({val_w[0][VAL_W-1], val_w[0]})
                  + $signed({{(SUM_W-OFS_W){offset[OFS_W-1]}}, offset});
  assign cp_real  = $signed({cp_w[0][VAL_W-1], cp_w[0]})
                  + $signed({{(SUM_W-OFS_W){offset[OFS_W-1]}}, offset});
  assign below    = valid_w[0] && (low_real < $signed({{(SUM_W-ARG_W){1'b0}}, threshold}));

  assign count_r  = {{(RANK_W-CW){1'b0}}, count};
  assign diff_r   = count_r - {1'b0, in_arg};
  assign hit      = (in_arg != '0) && ({1'b0, in_arg} <= count_r);
  assign count_ext = {{CNT_OUT_W{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op = CELL_HOLD;
    ctl.s  = s_wide[VAL_W-1:0];
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op)
            OP_INSERT: begin
              if (in_arg >= threshold && count != CW'(CAPACITY)) begin
                ctl.op = CELL_INSERT;
              end
              state_next = ST_FINISH;
            end
            OP_ADD: state_next = ST_FINISH;
            OP_SUB: state_next = ST_EVICT;
            OP_QUERY: begin
              if (hit) begin
                ctl.op = CELL_LOAD;
                state_next = ST_QUERY;
              end else begin
                state_next = ST_FINISH;
              end
            end
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_EVICT: begin
        if (below) begin
          ctl.op = CELL_SHIFT;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_QUERY: begin
        if (rem != '0) begin
          ctl.op = CELL_COPY;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      offset    <= '0;
      count     <= '0;
      departed  <= '0;
      ovf       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (state == ST_FINISH && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_op)
              OP_INSERT: begin
                if (in_arg >= threshold) begin
                  if (count == CW'(CAPACITY)) begin
                    ovf <= 1'b1;
                  end else begin
                    count <= count + 1'b1;
                  end
                end
              end
              OP_ADD: begin
                if (ofs_add > OFS_MAX) offset <= OFS_MAX[OFS_W-1:0];
                else offset <= ofs_add[OFS_W-1:0];
              end
              OP_SUB: begin
                if (ofs_sub < OFS_MIN) offset <= OFS_MIN[OFS_W-1:0];
                else offset <= ofs_sub[OFS_W-1:0];
              end
              default: ;
            endcase
          end
        end
        ST_EVICT: begin
          if (below) begin
            count <= count - 1'b1;
            if (departed != '1) departed <= departed + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result payload and query bookkeeping
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      found <= 1'b0;
      kval  <= (in_op == OP_QUERY) ? '1 : '0;
      rem   <= diff_r[IW-1:0];
    end else if (state == ST_QUERY) begin
      if (rem != '0) begin
        rem <= rem - 1'b1;
      end else begin
        found <= 1'b1;
        if (cp_real > RES_MAX) kval <= RES_MAX[RES_W-1:0];
        else if (cp_real < RES_MIN) kval <= RES_MIN[RES_W-1:0];
        else kval <= cp_real[RES_W-1:0];
      end
    end
    if (state == ST_FINISH && out_free) begin
      m_axis_tdata <= {2'b00, ovf, count_ext[CNT_OUT_W-1:0], departed, found, kval};
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] pv, nv, nc;
    logic                    pvd, pg, nvd;
    if (i == 0) begin : g_first
      assign pv  = '0;
      assign pvd = 1'b1;
      assign pg  = 1'b0;
    end else begin : g_mid
      assign pv  = val_w[i-1];
      assign pvd = valid_w[i-1];
      assign pg  = gt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nv  = '0;
      assign nvd = 1'b0;
      assign nc  = '0;
    end else begin : g_inner
      assign nv  = val_w[i+1];
      assign nvd = valid_w[i+1];
      assign nc  = cp_w[i+1];
    end
    osk_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .prev_val   (pv),
      .prev_valid (pvd),
      .prev_gt    (pg),
      .next_val   (nv),
      .next_valid (nvd),
      .next_cp    (nc),
      .val        (val_w[i]),
      .valid      (valid_w[i]),
      .gt         (gt_w[i]),
      .cp         (cp_w[i])
    );
  end

endmodule
